// File: design/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
// Used by every module of the block; depends on nothing else.
package npcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CH_W          = 16;
    localparam int IDX_W         = 8;
    localparam int DIST_W        = 34;
    localparam int SQ_W          = 2 * CH_W;
    localparam int SIZE_W        = 9;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 9;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_METRIC = 1'd1;

    localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = SIZE_W'(256);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] entry_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [CH_W-1:0]   best_red;
        logic [CH_W-1:0]   best_green;
        logic [CH_W-1:0]   best_blue;
        logic [DIST_W-1:0] best_distance;
    } out_item_t;

    // Control that travels with each palette entry through the search pipeline.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] index;
    } scan_tag_t;

endpackage

// File: design/nearest_palette_color_search.sv
// Nearest palette color search: loads write one palette entry and give no result. A
// query reads entries 0 to palette_size-1 (0 counts as 1, values above the depth are
// clamped) one per cycle through the single read port of the palette memory. Each
// entry passes through one memory read, three distance stages and the minimum update;
// the result register follows, and only then is the next request taken.
// Configuration may be written only while no query is in flight.
// Depends on npcs_pkg, npcs_palette_ram, npcs_dist_unit and npcs_min_tracker.
module nearest_palette_color_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  npcs_pkg::in_item_t              req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output npcs_pkg::out_item_t             rsp,
    input  logic                            cfg_write,
    input  logic [npcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import npcs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SIZE_W-1:0] palette_size_reg;
    logic              metric_reg;
    color_t            target_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] last_addr_reg, last_addr_next;
    scan_tag_t         rd_tag_reg, issue_tag;
    logic              rsp_valid_reg;
    out_item_t         rsp_reg;

    logic              req_accept;
    logic              ram_we;
    logic              start;
    logic              push;
    logic              load_in_range;
    color_t            req_color;
    color_t            ram_rdata;
    scan_tag_t         dist_tag;
    color_t            dist_color;
    logic [DIST_W-1:0] dist_value;
    logic              trk_done;
    logic [ADDR_W-1:0] trk_index;
    color_t            trk_color;
    logic [DIST_W-1:0] trk_dist;

    assign req_stall     = (state_reg != S_IDLE);
    assign req_accept    = req_valid && !req_stall;
    assign load_in_range = (32'(req.entry_index) < PALETTE_DEPTH);
    assign ram_we        = req_accept && (req.mode == MODE_LOAD) && load_in_range;
    assign start         = req_accept && (req.mode == MODE_QUERY);
    assign req_color     = '{red: req.red, green: req.green, blue: req.blue};

    // Last address searched, from the saturated palette size.
    always_comb
    begin
        priority if (palette_size_reg == '0)
        begin
            last_addr_next = '0;
        end
        else if (32'(palette_size_reg) > PALETTE_DEPTH)
        begin
            last_addr_next = ADDR_W'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_addr_next = ADDR_W'(palette_size_reg - SIZE_W'(1));
        end
    end

    always_comb
    begin
        issue_tag.valid = (state_reg == S_SCAN);
        issue_tag.last  = (addr_reg == last_addr_reg);
        issue_tag.index = addr_reg;
    end

    assign push = (state_reg == S_WAIT) && trk_done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    addr_next  = '0;
                end
            end
            S_SCAN:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (issue_tag.last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            addr_reg         <= '0;
            rd_tag_reg       <= '0;
            rsp_valid_reg    <= 1'b0;
            palette_size_reg <= PALETTE_SIZE_RESET;
            metric_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rd_tag_reg <= issue_tag;
            if (push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PALETTE_SIZE:    palette_size_reg <= SIZE_W'(cfg_data);
                    REG_DISTANCE_METRIC: metric_reg       <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            target_reg    <= req_color;
            last_addr_reg <= last_addr_next;
        end
        if (push)
        begin
            rsp_reg.best_index    <= IDX_W'(trk_index);
            rsp_reg.best_red      <= trk_color.red;
            rsp_reg.best_green    <= trk_color.green;
            rsp_reg.best_blue     <= trk_color.blue;
            rsp_reg.best_distance <= trk_dist;
        end
    end

    npcs_palette_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(req.entry_index)),
        .wdata (req_color),
        .re    (issue_tag.valid),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    npcs_dist_unit u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .metric    (metric_reg),
        .target    (target_reg),
        .in_tag    (rd_tag_reg),
        .in_color  (ram_rdata),
        .out_tag   (dist_tag),
        .out_color (dist_color),
        .out_dist  (dist_value)
    );

    npcs_min_tracker u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .take       (push),
        .tag        (dist_tag),
        .color      (dist_color),
        .distance   (dist_value),
        .done       (trk_done),
        .best_index (trk_index),
        .best_color (trk_color),
        .best_dist  (trk_dist)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The palette is never written while a query is reading it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !ram_we)
        else $error("palette write during a query");

    // A finished search is only reported while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        trk_done |-> (state_reg == S_WAIT))
        else $error("search finished outside the wait state");

    // Reads never go past the last searched entry.
    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue_tag.valid |-> (addr_reg <= last_addr_reg))
        else $error("palette read beyond the search range");

    // The scan walks the palette one entry per cycle.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_tag.valid && !issue_tag.last) |=> (addr_reg == $past(addr_reg) + ADDR_W'(1)))
        else $error("scan address did not advance");

endmodule

// File: design/npcs_palette_ram.sv
// Palette storage: one write port and one read port with registered read data.
// Depends on npcs_pkg for the depth and the color type.
module npcs_palette_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [npcs_pkg::ADDR_W-1:0] waddr,
    input  npcs_pkg::color_t          wdata,
    input  logic                      re,
    input  logic [npcs_pkg::ADDR_W-1:0] raddr,
    output npcs_pkg::color_t          rdata
);
    import npcs_pkg::*;

    color_t mem [PALETTE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/npcs_dist_unit.sv
// Three-stage distance pipeline: channel differences, squares, then sum or maximum.
// Depends on npcs_pkg for widths, the color type and the scan tag.
module npcs_dist_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        metric,
    input  npcs_pkg::color_t            target,
    input  npcs_pkg::scan_tag_t         in_tag,
    input  npcs_pkg::color_t            in_color,
    output npcs_pkg::scan_tag_t         out_tag,
    output npcs_pkg::color_t            out_color,
    output logic [npcs_pkg::DIST_W-1:0] out_dist
);
    import npcs_pkg::*;

    scan_tag_t         s1_tag_reg, s2_tag_reg, s3_tag_reg;
    color_t            s1_color_reg, s2_color_reg, s3_color_reg;
    logic [CH_W-1:0]   dr_reg, dg_reg, db_reg;
    logic [CH_W-1:0]   dr_next, dg_next, db_next;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CH_W-1:0]   max_reg, max_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        dr_next = abs_diff(in_color.red, target.red);
        dg_next = abs_diff(in_color.green, target.green);
        db_next = abs_diff(in_color.blue, target.blue);
    end

    always_comb
    begin
        max_next = dr_reg;
        if (dg_reg > max_next)
        begin
            max_next = dg_reg;
        end
        if (db_reg > max_next)
        begin
            max_next = db_reg;
        end
    end

    always_comb
    begin
        if (metric)
        begin
            dist_next = DIST_W'(max_reg);
        end
        else
        begin
            dist_next = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_color_reg <= in_color;
        dr_reg       <= dr_next;
        dg_reg       <= dg_next;
        db_reg       <= db_next;

        s2_color_reg <= s1_color_reg;
        sq_r_reg     <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sq_g_reg     <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sq_b_reg     <= SQ_W'(db_reg) * SQ_W'(db_reg);
        max_reg      <= max_next;

        s3_color_reg <= s2_color_reg;
        dist_reg     <= dist_next;
    end

    assign out_tag   = s3_tag_reg;
    assign out_color = s3_color_reg;
    assign out_dist  = dist_reg;

endmodule

// File: design/npcs_min_tracker.sv
// Keeps the closest entry seen so far in a scan; the first minimum wins a tie.
// Depends on npcs_pkg for widths, the color type and the scan tag.
module npcs_min_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        take,
    input  npcs_pkg::scan_tag_t         tag,
    input  npcs_pkg::color_t            color,
    input  logic [npcs_pkg::DIST_W-1:0] distance,
    output logic                        done,
    output logic [npcs_pkg::ADDR_W-1:0] best_index,
    output npcs_pkg::color_t            best_color,
    output logic [npcs_pkg::DIST_W-1:0] best_dist
);
    import npcs_pkg::*;

    logic              done_reg;
    logic [ADDR_W-1:0] best_index_reg;
    color_t            best_color_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              update;

    // Entry zero always opens the scan; later entries must be strictly closer.
    assign update = tag.valid && ((tag.index == '0) || (distance < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (start || take)
        begin
            done_reg <= 1'b0;
        end
        else if (tag.valid && tag.last)
        begin
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            best_index_reg <= tag.index;
            best_color_reg <= color;
            best_dist_reg  <= distance;
        end
    end

    assign done       = done_reg;
    assign best_index = best_index_reg;
    assign best_color = best_color_reg;
    assign best_dist  = best_dist_reg;

endmodule

// File: verif/tb.sv
// Testbench for nearest_palette_color_search: random and directed palette loads and queries,
// with results checked against a scoreboard that predicts each nearest-color match.
// Depends on npcs_pkg and the nearest_palette_color_search RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npcs_pkg::*;

    localparam int unsigned PHASE_COUNT = 16;
    localparam int unsigned PHASE_SIZES [PHASE_COUNT] =
        '{256, 2, 511, 1, 0, 3, 257, 5, 8, 255, 16, 33, 64, 128, 7, 2};
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    class palette_scoreboard;
        color_t            palette [PALETTE_DEPTH];
        logic [SIZE_W-1:0] size_reg;
        bit                chebyshev;
        out_item_t         pending_matches [$];
        int                error_count;
        int                loads_seen;
        int                queries_seen;
        int                matches_checked;

        function new();
            size_reg  = PALETTE_SIZE_RESET;
            chebyshev = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PALETTE_SIZE:    size_reg  = data[SIZE_W-1:0];
                REG_DISTANCE_METRIC: chebyshev = data[0];
                default: ;
            endcase
        endfunction

        // A size of zero still searches entry 0, and sizes past the depth are clamped.
        function int unsigned search_count();
            if (size_reg == 0)
                return 1;
            if (size_reg > PALETTE_DEPTH)
                return PALETTE_DEPTH;
            return size_reg;
        endfunction

        function logic [DIST_W-1:0] color_distance(color_t entry, color_t target);
            logic [CH_W-1:0] dr;
            logic [CH_W-1:0] dg;
            logic [CH_W-1:0] db;
            logic [CH_W-1:0] top;
            dr = (entry.red   >= target.red)   ? entry.red   - target.red
                                               : target.red   - entry.red;
            dg = (entry.green >= target.green) ? entry.green - target.green
                                               : target.green - entry.green;
            db = (entry.blue  >= target.blue)  ? entry.blue  - target.blue
                                               : target.blue  - entry.blue;
            if (chebyshev)
            begin
                top = dr;
                if (dg > top)
                    top = dg;
                if (db > top)
                    top = db;
                return DIST_W'(top);
            end
            return DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg)
                 + DIST_W'(db) * DIST_W'(db);
        endfunction

        function void note_request(in_item_t item);
            out_item_t         match;
            color_t            target;
            logic [DIST_W-1:0] d;
            int unsigned       n;
            if (item.mode == MODE_LOAD)
            begin
                palette[item.entry_index] = '{item.red, item.green, item.blue};
                loads_seen++;
                return;
            end
            target = '{item.red, item.green, item.blue};
            n = search_count();
            match.best_index    = '0;
            match.best_distance = color_distance(palette[0], target);
            // Only a strictly smaller distance moves the best, so the lowest index wins ties.
            for (int unsigned i = 1; i < n; i++)
            begin
                d = color_distance(palette[i], target);
                if (d < match.best_distance)
                begin
                    match.best_distance = d;
                    match.best_index    = IDX_W'(i);
                end
            end
            {match.best_red, match.best_green, match.best_blue} = palette[match.best_index];
            pending_matches.push_back(match);
            queries_seen++;
        endfunction

        function void compare_field(string field, logic [DIST_W-1:0] want,
                                    logic [DIST_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                error_count++;
            end
        endfunction

        function void check_match(out_item_t got);
            out_item_t want;
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result: best_index %0d, best_distance %0d",
                       got.best_index, got.best_distance);
                error_count++;
                return;
            end
            want = pending_matches.pop_front();
            matches_checked++;
            compare_field("best_index", DIST_W'(want.best_index), DIST_W'(got.best_index));
            compare_field("best_red", DIST_W'(want.best_red), DIST_W'(got.best_red));
            compare_field("best_green", DIST_W'(want.best_green), DIST_W'(got.best_green));
            compare_field("best_blue", DIST_W'(want.best_blue), DIST_W'(got.best_blue));
            compare_field("best_distance", want.best_distance, got.best_distance);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    in_item_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    out_item_t             rsp;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    palette_scoreboard sb = new();

    int          hold_off_left = 0;
    int unsigned stall_pct     = 0;
    int unsigned burst_left    = 0;
    int unsigned gap_max       = 0;

    nearest_palette_color_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_match(rsp);
        end
    end

    // The result side stalls in runs of random length; a long hold-off, once asked for,
    // overrides the pattern until its count runs out.
    initial
    begin
        int unsigned run_left;
        bit          run_stall;
        run_left  = 0;
        run_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left  = $urandom_range(1, 12);
                    run_stall = ($urandom_range(99) < stall_pct);
                end
                run_left--;
                rsp_stall <= run_stall;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_request(input in_item_t item);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles == 0)
            return;
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle_sender($urandom_range(0, gap_max));
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_matches.size() != 0)
            @(posedge clk);
    endtask

    // A load gives no result, so settling waits for every pending match and then lets
    // the block sit idle before the next configuration.
    task automatic settle();
        wait_drained();
        repeat (sb.search_count() + 8) @(posedge clk);
    endtask

    task automatic set_search(input int unsigned size, input bit metric);
        cfg_write <= 1'b1;
        cfg_index <= REG_PALETTE_SIZE;
        cfg_data  <= CFG_DATA_W'(size);
        @(posedge clk);
        sb.set_register(REG_PALETTE_SIZE, CFG_DATA_W'(size));
        cfg_index <= REG_DISTANCE_METRIC;
        cfg_data  <= CFG_DATA_W'(metric);
        @(posedge clk);
        sb.set_register(REG_DISTANCE_METRIC, CFG_DATA_W'(metric));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        in_item_t item;
        item.mode        = MODE_LOAD;
        item.entry_index = idx;
        item.red         = r;
        item.green       = g;
        item.blue        = b;
        send_request(item);
    endtask

    task automatic query_color(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                               input logic [CH_W-1:0] b);
        in_item_t item;
        item.mode        = MODE_QUERY;
        item.entry_index = IDX_W'($urandom);
        item.red         = r;
        item.green       = g;
        item.blue        = b;
        send_request(item);
    endtask

    function automatic logic [CH_W-1:0] extreme();
        return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [CH_W-1:0] nudge(logic [CH_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(128)) - 64;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return CH_W'(v);
    endfunction

    // Loads mostly land inside the searched range and often copy another entry,
    // which makes ties between entries common.
    function automatic in_item_t random_load(int unsigned count);
        in_item_t    item;
        color_t      twin;
        int unsigned pick;
        item.mode        = MODE_LOAD;
        item.entry_index = ($urandom_range(99) < 70) ? IDX_W'($urandom_range(count - 1))
                                                     : IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            twin = sb.palette[$urandom_range(count - 1)];
            item.red   = twin.red;
            item.green = twin.green;
            item.blue  = twin.blue;
        end
        else if (pick < 40)
        begin
            item.red   = extreme();
            item.green = extreme();
            item.blue  = extreme();
        end
        else
        begin
            item.red   = CH_W'($urandom);
            item.green = CH_W'($urandom);
            item.blue  = CH_W'($urandom);
        end
        return item;
    endfunction

    function automatic in_item_t random_query(int unsigned count);
        in_item_t    item;
        color_t      near;
        int unsigned pick;
        item.mode        = MODE_QUERY;
        item.entry_index = IDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            near = sb.palette[$urandom_range(count - 1)];
            item.red   = nudge(near.red);
            item.green = nudge(near.green);
            item.blue  = nudge(near.blue);
        end
        else if (pick < 70)
        begin
            item.red   = extreme();
            item.green = extreme();
            item.blue  = extreme();
        end
        else
        begin
            item.red   = CH_W'($urandom);
            item.green = CH_W'($urandom);
            item.blue  = CH_W'($urandom);
        end
        return item;
    endfunction

    initial
    begin
        int unsigned count;
        int unsigned n_items;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: corner colors, a duplicate entry for the tie rule, the top index.
        set_search(4, 1'b0);
        load_entry(8'd0, 16'h0000, 16'h0000, 16'h0000);
        load_entry(8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_entry(8'd2, 16'hFFFF, 16'h0000, 16'h8000);
        load_entry(8'd3, 16'h0000, 16'h0000, 16'h0000);
        load_entry(8'd255, 16'hA5A5, 16'h5A5A, 16'hFFFF);
        query_color(16'h0000, 16'h0000, 16'h0000);
        query_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
        query_color(16'hFFFF, 16'h0000, 16'h8000);
        query_color(16'h0001, 16'h0002, 16'h0003);
        settle();
        set_search(4, 1'b1);
        query_color(16'h8000, 16'h8000, 16'h8000);
        query_color(16'h0000, 16'hFFFF, 16'h0000);
        settle();
        // With a zero size only entry 0 is searched; white against it is the largest distance.
        set_search(0, 1'b0);
        query_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
        query_color(16'h0000, 16'h0000, 16'h0000);
        settle();
        set_search(0, 1'b1);
        query_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // Fill every entry so that any search range reads only written entries.
        set_search(256, 1'b0);
        gap_max   = 6;
        stall_pct = 30;
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            pace_sender();
            load_entry(IDX_W'(i), CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            set_search(PHASE_SIZES[p], p[0]);
            count     = sb.search_count();
            n_items   = (count >= 128) ? 20 : 43;
            gap_max   = (p % 4 == 0) ? 0 : $urandom_range(2, 10);
            stall_pct = (p % 5 == 0) ? 0 : $urandom_range(10, 70);
            burst_left = 0;
            // Hold results back for a long stretch while requests keep coming, so the
            // block backs up and stalls its request side.
            if (p == 1)
            begin
                gap_max       = 0;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            for (int k = 0; k < n_items; k++)
            begin
                pace_sender();
                if ($urandom_range(99) < 35)
                    send_request(random_load(count));
                else
                    send_request(random_query(count));
                if (p == 2 && k == n_items / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (PALETTE_DEPTH + 16) @(posedge clk);
        if (sb.pending_matches.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_matches.size());
            sb.error_count++;
        end
        $display("Checked %0d nearest-color results from %0d queries and %0d palette loads,",
                 sb.matches_checked, sb.queries_seen, sb.loads_seen);
        $display("over search sizes 0 to 511, both metrics, random stalls and a long hold-off.");
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
design/npcs_pkg.sv
design/npcs_palette_ram.sv
design/npcs_dist_unit.sv
design/npcs_min_tracker.sv
design/nearest_palette_color_search.sv
verif/tb.sv
